[rtl/ps2hbs_pkg.sv]
`default_nettype none
package ps2hbs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_INHIBIT = 3'd1,
    PH_START   = 3'd2,
    PH_RELEASE = 3'd3,
    PH_FRAME   = 3'd4,
    PH_ACK     = 3'd5
  } phase_t;

  localparam logic [1:0] REG_INHIBIT = 2'd0;
  localparam logic [1:0] REG_START   = 2'd1;
  localparam logic [1:0] REG_RELEASE = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  localparam logic [7:0]  INHIBIT_RST = 8'd120;
  localparam logic [7:0]  START_RST   = 8'd20;
  localparam logic [7:0]  RELEASE_RST = 8'd50;
  localparam logic [15:0] TIMEOUT_RST = 16'd32000;

  localparam logic [3:0] BIT_PARITY = 4'd8;
  localparam logic [3:0] BIT_STOP   = 4'd9;

endpackage
`default_nettype wire

[rtl/ps2_host_byte_sender_unit.sv]
// PS/2 host-to-device byte sender, host side.
// Input stream: one word per line sample tick. in_tuser is the function
// (0 = sample only, 1 = start sending in_tdata byte). in_tdata carries the
// byte plus the sampled clock and data line levels.
// Output stream: one result word per input word, giving the line drives
// (clock/data pull-low) and busy, done, ack_ok and rejected flags.
// The result of a word accepted at one edge is presented from the next
// cycle in the output register. A new word can be accepted every cycle
// while the receiver takes results; the per-tick state update is a single
// pass of small counter and compare logic ahead of the output register.
// If the receiver stalls, the held result stays in the output register and
// input is accepted in the same cycle the result is taken.
// Configuration (cfg_we/cfg_index/cfg_data) sets the inhibit, start,
// release and timeout tick counts; write only while no send is active.
// Reset (synchronous, rst_n low) returns the sender to idle with both lines
// released, restores the default tick counts and empties the output register.
`default_nettype none
module ps2_host_byte_sender_unit
  import ps2hbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // [7:0] tx_byte, [8] clock_in, [9] data_in
  input  wire logic        in_tuser,  // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] clock_drive_low, [1] data_drive_low, [2] busy_res, [3] done_res,
  // [4] ack_ok, [5] rejected
  output logic [7:0]       out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [7:0]  inhibit_r, start_r, release_r;
  logic [15:0] timeout_r;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        parity_r, parity_nxt;
  logic        await_r, await_nxt;
  logic [7:0]  dly_r, dly_nxt;
  logic [15:0] tmo_r, tmo_nxt;
  logic        dlvl_r, dlvl_nxt;

  logic        out_valid_r;
  logic [5:0]  res_r, res_nxt;

  logic        func, clk_in, dat_in, accept;
  logic [7:0]  tx_byte, dly_inc, limit;
  logic [15:0] tmo_inc;
  logic        done, ack, rej;

  assign func    = in_tuser;
  assign tx_byte = in_tdata[7:0];
  assign clk_in  = in_tdata[8];
  assign dat_in  = in_tdata[9];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inhibit_r <= INHIBIT_RST;
      start_r   <= START_RST;
      release_r <= RELEASE_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INHIBIT: inhibit_r <= cfg_data[7:0];
        REG_START:   start_r   <= cfg_data[7:0];
        REG_RELEASE: release_r <= cfg_data[7:0];
        REG_TIMEOUT: timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state for one sample tick
  always_comb begin
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    parity_nxt  = parity_r;
    await_nxt   = await_r;
    dly_nxt     = dly_r;
    tmo_nxt     = tmo_r;
    dlvl_nxt    = dlvl_r;
    done        = 1'b0;
    ack         = 1'b0;
    rej         = 1'b0;
    dly_inc     = dly_r + 8'd1;
    tmo_inc     = tmo_r + 16'd1;
    limit       = release_r;
    if (phase_r == PH_INHIBIT) limit = inhibit_r;
    else if (phase_r == PH_START) limit = start_r;

    unique case (phase_r) inside
      PH_INHIBIT, PH_START, PH_RELEASE: begin
        rej     = func;
        dly_nxt = dly_inc;
        if (dly_inc >= limit || dly_inc == 8'd0) begin
          dly_nxt = 8'd0;
          if (phase_r == PH_INHIBIT) begin
            dlvl_nxt  = 1'b1;
            phase_nxt = PH_START;
          end else if (phase_r == PH_START) begin
            phase_nxt = PH_RELEASE;
          end else begin
            tmo_nxt   = 16'd0;
            await_nxt = 1'b0;
            phase_nxt = PH_FRAME;
          end
        end
      end
      PH_FRAME, PH_ACK: begin
        rej     = func;
        tmo_nxt = tmo_inc;
        if (tmo_inc >= timeout_r || tmo_inc == 16'd0) begin
          done = 1'b1;
        end else if (phase_r == PH_ACK) begin
          if (!dat_in) begin
            done = 1'b1;
            ack  = 1'b1;
          end
        end else if (await_r) begin
          if (clk_in) begin
            await_nxt   = 1'b0;
            bit_idx_nxt = bit_idx_r + 4'd1;
          end
        end else if (!clk_in) begin
          if (bit_idx_r < BIT_PARITY) begin
            dlvl_nxt   = !shift_r[0];
            parity_nxt = parity_r ^ shift_r[0];
            shift_nxt  = {1'b0, shift_r[7:1]};
            await_nxt  = 1'b1;
          end else if (bit_idx_r == BIT_PARITY) begin
            // odd parity: drive low when the data xor is 1
            dlvl_nxt  = parity_r;
            await_nxt = 1'b1;
          end else if (bit_idx_r == BIT_STOP) begin
            dlvl_nxt  = 1'b0;
            await_nxt = 1'b1;
          end else begin
            dlvl_nxt = 1'b0;
            if (!dat_in) begin
              done = 1'b1;
              ack  = 1'b1;
            end else begin
              phase_nxt = PH_ACK;
            end
          end
        end
        if (done) begin
          phase_nxt = PH_IDLE;
          dlvl_nxt  = 1'b0;
          await_nxt = 1'b0;
        end
      end
      default: begin
        // idle, and unused codes behave as idle
        phase_nxt = PH_IDLE;
        if (func) begin
          shift_nxt   = tx_byte;
          parity_nxt  = 1'b0;
          bit_idx_nxt = 4'd0;
          await_nxt   = 1'b0;
          dly_nxt     = 8'd0;
          tmo_nxt     = 16'd0;
          dlvl_nxt    = 1'b0;
          phase_nxt   = PH_INHIBIT;
        end
      end
    endcase
  end

  always_comb begin
    res_nxt[0] = (phase_nxt == PH_INHIBIT) || (phase_nxt == PH_START);
    res_nxt[1] = (phase_nxt != PH_IDLE) && dlvl_nxt;
    res_nxt[2] = phase_nxt != PH_IDLE;
    res_nxt[3] = done;
    res_nxt[4] = ack;
    res_nxt[5] = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_idx_r   <= 4'd0;
      shift_r     <= 8'd0;
      parity_r    <= 1'b0;
      await_r     <= 1'b0;
      dly_r       <= 8'd0;
      tmo_r       <= 16'd0;
      dlvl_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        bit_idx_r <= bit_idx_nxt;
        shift_r   <= shift_nxt;
        parity_r  <= parity_nxt;
        await_r   <= await_nxt;
        dly_r     <= dly_nxt;
        tmo_r     <= tmo_nxt;
        dlvl_r    <= dlvl_nxt;
      end
      if (accept) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

endmodule
`default_nettype wire

[verif/ps2_host_byte_sender_unit_tb.sv]
`timescale 1ns / 1ps
module ps2_host_byte_sender_unit_tb
  import ps2hbs_pkg::*;
();

  localparam int IDLE_LIMIT = 2000;
  localparam int SEND_FULL  = 0;
  localparam int SEND_CUT   = 1;
  localparam int SEND_NOACK = 2;

  typedef struct packed {
    logic       func;
    logic [7:0] tx_byte;
    logic       clk_lvl;
    logic       dat_lvl;
  } tick_t;

  // bit 0 is clock_drive_low, same order as out_tdata
  typedef struct packed {
    logic rej;
    logic ack;
    logic done;
    logic busy;
    logic dat_low;
    logic clk_low;
  } drive_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_INHIBIT;
  logic [15:0] cfg_data = '0;

  ps2_host_byte_sender_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  tick_t  pend_ticks[$];
  drive_t drive_q[$];
  tick_t  cur_tick;
  int     issued = 0;
  int     errs = 0;
  int     in_gap = 0;
  int     stall_left = 0;
  int     idle_cycles = 0;
  bit     quiet = 1'b0;
  bit     no_stray = 1'b0;
  string  field_name [6] = '{"clock_drive_low", "data_drive_low", "busy_res",
                             "done_res", "ack_ok", "rejected"};

  // sender state as the block should hold it
  phase_t      line_phase = PH_IDLE;
  logic [3:0]  bit_idx = '0;
  logic [7:0]  sh_byte = '0;
  logic        par = 1'b0;
  logic        await_hi = 1'b0;
  logic        data_low_q = 1'b0;
  logic [7:0]  dly = '0;
  logic [15:0] tmo = '0;
  logic [7:0]  inh_lim = INHIBIT_RST;
  logic [7:0]  st_lim = START_RST;
  logic [7:0]  rel_lim = RELEASE_RST;
  logic [15:0] to_lim = TIMEOUT_RST;

  function automatic drive_t sender_step(tick_t t);
    drive_t     r;
    logic [7:0] lim;
    logic       fin;
    logic       ok;
    r = '0;
    fin = 1'b0;
    ok = 1'b0;
    if (line_phase == PH_IDLE) begin
      if (t.func) begin
        sh_byte = t.tx_byte;
        par = 1'b0;
        bit_idx = '0;
        await_hi = 1'b0;
        dly = '0;
        tmo = '0;
        data_low_q = 1'b0;
        line_phase = PH_INHIBIT;
      end
    end else begin
      r.rej = t.func;
      if (line_phase == PH_INHIBIT || line_phase == PH_START || line_phase == PH_RELEASE) begin
        lim = (line_phase == PH_INHIBIT) ? inh_lim :
              (line_phase == PH_START) ? st_lim : rel_lim;
        dly = dly + 8'd1;
        // a zero limit behaves like one tick
        if (dly >= lim || dly == 8'd0) begin
          dly = '0;
          case (line_phase)
            PH_INHIBIT: begin
              data_low_q = 1'b1;
              line_phase = PH_START;
            end
            PH_START: line_phase = PH_RELEASE;
            default: begin
              tmo = '0;
              await_hi = 1'b0;
              line_phase = PH_FRAME;
            end
          endcase
        end
      end else begin
        tmo = tmo + 16'd1;
        if (tmo >= to_lim || tmo == 16'd0) begin
          fin = 1'b1;
        end else if (line_phase == PH_ACK) begin
          if (!t.dat_lvl) begin
            fin = 1'b1;
            ok = 1'b1;
          end
        end else if (await_hi) begin
          if (t.clk_lvl) begin
            await_hi = 1'b0;
            bit_idx = bit_idx + 4'd1;
          end
        end else if (!t.clk_lvl) begin
          if (bit_idx < BIT_PARITY) begin
            data_low_q = ~sh_byte[0];
            par = par ^ sh_byte[0];
            sh_byte = sh_byte >> 1;
            await_hi = 1'b1;
          end else if (bit_idx == BIT_PARITY) begin
            // odd parity: line low when the data xor is one
            data_low_q = par;
            await_hi = 1'b1;
          end else if (bit_idx == BIT_STOP) begin
            data_low_q = 1'b0;
            await_hi = 1'b1;
          end else begin
            data_low_q = 1'b0;
            if (!t.dat_lvl) begin
              fin = 1'b1;
              ok = 1'b1;
            end else begin
              line_phase = PH_ACK;
            end
          end
        end
      end
    end
    if (fin) begin
      line_phase = PH_IDLE;
      data_low_q = 1'b0;
      await_hi = 1'b0;
      r.done = 1'b1;
      r.ack = ok;
    end
    r.clk_low = (line_phase == PH_INHIBIT || line_phase == PH_START);
    r.dat_low = (line_phase != PH_IDLE) && data_low_q;
    r.busy = (line_phase != PH_IDLE);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) drive_q.push_back(sender_step(cur_tick));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pend_ticks.size() != 0) begin
          cur_tick = pend_ticks.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_tick.func;
          in_tdata <= {6'd0, cur_tick.dat_lvl, cur_tick.clk_lvl, cur_tick.tx_byte};
          if (!quiet && $urandom_range(0, 15) == 0) in_gap = $urandom_range(1, 9);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin : mon
    drive_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (drive_q.size() == 0) begin
          $error("result word with no expectation: %h", out_tdata);
          errs++;
        end else begin
          want = drive_q.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (out_tdata[i] !== want[i]) begin
              $error("%s: expected %0b, got %0b", field_name[i], want[i], out_tdata[i]);
              errs++;
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  function automatic bit stray_start();
    return !no_stray && ($urandom_range(0, 19) == 0);
  endfunction

  task automatic add_tick(input bit f, input logic [7:0] b, input bit c, input bit d);
    tick_t t;
    t.func = f;
    t.tx_byte = b;
    t.clk_lvl = c;
    t.dat_lvl = d;
    pend_ticks.push_back(t);
    issued++;
  endtask

  // one host-to-device send as a device would clock it
  task automatic queue_send(input logic [7:0] byte_v, input int mode, input bit poke);
    int hold;
    int nclk;
    int aw;
    hold = $urandom_range(0, 2);
    hold += (inh_lim == 8'd0) ? 1 : inh_lim;
    hold += (st_lim == 8'd0) ? 1 : st_lim;
    hold += (rel_lim == 8'd0) ? 1 : rel_lim;
    add_tick(1'b1, byte_v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    // device keeps its clock released during the hold-off, mostly
    for (int i = 0; i < hold; i++)
      add_tick((poke && i == 0) || stray_start(), 8'($urandom_range(0, 255)),
               ($urandom_range(0, 7) == 0) ? 1'($urandom_range(0, 1)) : 1'b1,
               1'($urandom_range(0, 1)));
    nclk = (mode == SEND_CUT) ? $urandom_range(1, 10) : 11;
    for (int k = 0; k < nclk; k++) begin
      repeat ($urandom_range(1, 3))
        add_tick(stray_start(), 8'($urandom_range(0, 255)), 1'b1,
                 1'($urandom_range(0, 1)));
      if (k < 10)
        repeat ($urandom_range(1, 3))
          add_tick(stray_start(), 8'($urandom_range(0, 255)), 1'b0,
                   1'($urandom_range(0, 1)));
    end
    if (nclk == 11) begin
      aw = (mode == SEND_NOACK) ? $urandom_range(2, 6) : $urandom_range(0, 3);
      add_tick(1'b0, 8'($urandom_range(0, 255)), 1'b0, aw != 0);
      if (aw > 0) begin
        repeat (aw - 1)
          add_tick(stray_start(), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'b1);
        if (mode != SEND_NOACK)
          add_tick(stray_start(), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'b0);
      end
    end
  endtask

  task automatic run_mix(input int budget);
    int         first;
    int         pick;
    logic [7:0] b;
    first = issued;
    while (issued - first < budget) begin
      pick = $urandom_range(0, 9);
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if (pick < 7)
        queue_send(b, SEND_FULL, 1'b0);
      else if (pick < 9)
        queue_send(b, (pick == 7) ? SEND_CUT : SEND_NOACK, 1'b0);
      else
        repeat ($urandom_range(1, 8))
          add_tick($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain();
    while (pend_ticks.size() != 0 || drive_q.size() != 0 || in_tvalid) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // finish any send still open by clocking the frame through with data low
  task automatic settle_idle();
    bit c;
    c = 1'b0;
    drain();
    while (line_phase != PH_IDLE) begin
      c = ~c;
      add_tick(1'b0, 8'($urandom_range(0, 255)), c, 1'b0);
      drain();
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INHIBIT: inh_lim = val[7:0];
      REG_START:   st_lim = val[7:0];
      REG_RELEASE: rel_lim = val[7:0];
      REG_TIMEOUT: to_lim = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [7:0] inh, input logic [7:0] st,
                           input logic [7:0] rel, input logic [15:0] tmo_v);
    write_reg(REG_INHIBIT, {8'd0, inh});
    write_reg(REG_START, {8'd0, st});
    write_reg(REG_RELEASE, {8'd0, rel});
    write_reg(REG_TIMEOUT, tmo_v);
  endtask

  initial begin
    logic [15:0] tmo_pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // default tick counts out of reset
    run_mix(150);
    settle_idle();

    // shortest hold-off, longest timeout: start while busy, both byte extremes,
    // missing acknowledge
    apply_cfg(8'd1, 8'd1, 8'd1, 16'hFFFF);
    queue_send(8'h00, SEND_FULL, 1'b0);
    queue_send(8'hFF, SEND_NOACK, 1'b0);
    queue_send(8'hA5, SEND_FULL, 1'b1);
    settle_idle();
    run_mix(150);
    settle_idle();

    // zero delays last one tick; zero timeout fails on the first frame tick
    apply_cfg(8'd0, 8'd0, 8'd0, 16'd0);
    run_mix(60);
    settle_idle();

    // longest hold-off, timeout of one tick; no stray starts, each new send
    // here would cost several hundred ticks
    apply_cfg(8'd255, 8'd255, 8'd255, 16'd1);
    no_stray = 1'b1;
    queue_send(8'($urandom_range(0, 255)), SEND_FULL, 1'b0);
    settle_idle();
    no_stray = 1'b0;

    for (int p = 0; p < 3; p++) begin
      if (p == 2) quiet = 1'b1;
      case ($urandom_range(0, 2))
        0: tmo_pick = 16'($urandom_range(2, 40));
        1: tmo_pick = 16'($urandom_range(41, 300));
        default: tmo_pick = 16'hFFFF;
      endcase
      apply_cfg(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                8'($urandom_range(1, 6)), tmo_pick);
      run_mix(160);
      settle_idle();
    end

    repeat (4) @(posedge clk);
    if (errs == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
rtl/ps2hbs_pkg.sv
rtl/ps2_host_byte_sender_unit.sv
verif/ps2_host_byte_sender_unit_tb.sv
